### rtl/frga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package frga_pkg;

    localparam int unsigned MID_DEPTH_DEF = 2;
    localparam int unsigned OUT_DEPTH_DEF = 2;

    localparam logic [7:0]  ROW_FIRST   = 8'hA1;
    localparam logic [7:0]  ROW_LAST_A  = 8'hA9;
    localparam logic [7:0]  ROW_FIRST_B = 8'hB0;
    localparam logic [7:0]  ROW_LAST_B  = 8'hF7;
    localparam logic [6:0]  COLS        = 7'd94;
    localparam logic [12:0] B_OFFSET    = 13'd846;
    localparam logic [7:0]  PRINT_LO    = 8'h20;
    localparam logic [7:0]  PRINT_HI    = 8'h7E;

    localparam logic [1:0] FAM_GB2312 = 2'd0;
    localparam logic [0:0] CFG_FAMILY = 1'b0;
    localparam logic [0:0] CFG_SIZE   = 1'b1;

    typedef logic [12:0] idx_t;

    typedef struct packed {
        logic [23:0] base;
        logic [7:0]  n;
        logic [7:0]  adv;
    } size_entry_t;

    typedef struct packed {
        idx_t        idx;
        logic [23:0] base;
        logic [7:0]  n;
        logic [15:0] x;
        logic [15:0] y;
    } job_t;

    typedef struct packed {
        logic [23:0] addr;
        logic [7:0]  n;
        logic [15:0] x;
        logic [15:0] y;
    } result_t;

    // n of zero marks a size with no glyphs
    function automatic size_entry_t size_lookup(input logic [1:0] fam, input logic [2:0] sz);
        size_entry_t e;
        e = '{base: 24'h0, n: 8'd0, adv: 8'd0};
        case (fam)
            2'd0:
            begin
                case (sz)
                    3'd1: e = '{24'h000000, 8'd24, 8'd12};
                    3'd2: e = '{24'h02C9D0, 8'd32, 8'd16};
                    3'd3: e = '{24'h068190, 8'd72, 8'd24};
                    3'd4: e = '{24'h0EDF00, 8'd128, 8'd32};
                    default: e = '{24'h0, 8'd0, 8'd0};
                endcase
            end
            2'd1:
            begin
                case (sz)
                    3'd1: e = '{24'h1DDF80, 8'd8, 8'd6};
                    3'd2: e = '{24'h1DE280, 8'd8, 8'd8};
                    3'd3: e = '{24'h1DBE00, 8'd12, 8'd6};
                    3'd4: e = '{24'h1DD780, 8'd16, 8'd8};
                    3'd5: e = '{24'h1DFF00, 8'd48, 8'd12};
                    3'd6: e = '{24'h1E5A50, 8'd64, 8'd16};
                    default: e = '{24'h0, 8'd0, 8'd0};
                endcase
            end
            2'd2:
            begin
                case (sz)
                    3'd1: e = '{24'h1DC400, 8'd26, 8'd8};
                    3'd2: e = '{24'h1DE580, 8'd34, 8'd12};
                    3'd3: e = '{24'h1E22D0, 8'd74, 8'd16};
                    3'd4: e = '{24'h1E99D0, 8'd130, 8'd24};
                    default: e = '{24'h0, 8'd0, 8'd0};
                endcase
            end
            default:
            begin
                case (sz)
                    3'd1: e = '{24'h1DCDC0, 8'd26, 8'd8};
                    3'd2: e = '{24'h1DF240, 8'd34, 8'd12};
                    3'd3: e = '{24'h1E3E90, 8'd74, 8'd16};
                    3'd4: e = '{24'h1ECA90, 8'd130, 8'd24};
                    default: e = '{24'h0, 8'd0, 8'd0};
                endcase
            end
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

### rtl/frga_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module frga_fifo #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output logic [W-1:0]      rd_data,
    output logic              empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/frga_front.sv
`timescale 1ns / 1ps
`default_nettype none
module frga_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic [7:0]     text_byte,
    input  wire logic           start_string,
    input  wire logic [15:0]    start_x,
    input  wire logic [15:0]    start_y,
    input  wire logic           cfg_valid,
    input  wire logic [0:0]     cfg_index,
    input  wire logic [2:0]     cfg_data,
    input  wire logic           job_full,
    output logic                job_push,
    output frga_pkg::job_t      job
);
    import frga_pkg::*;

    logic [1:0]  family_reg;
    logic [2:0]  size_reg;
    logic [15:0] pen_x_reg, pen_x_next;
    logic [15:0] pen_y_reg, pen_y_next;
    logic [7:0]  lead_reg, lead_next;
    logic        second_reg, second_next;
    logic        ended_reg, ended_next;

    logic        accept;
    size_entry_t ent;
    logic        row_a, row_b;
    logic [6:0]  row_num;
    logic [7:0]  col;
    logic [13:0] row_base;

    assign accept = push && !job_full;
    assign ent    = size_lookup(family_reg, size_reg);
    assign row_a  = (lead_reg >= ROW_FIRST) && (lead_reg <= ROW_LAST_A);
    assign row_b  = (lead_reg >= ROW_FIRST_B) && (lead_reg <= ROW_LAST_B);
    assign row_num  = row_a ? 7'(lead_reg - ROW_FIRST) : 7'(lead_reg - ROW_FIRST_B);
    assign row_base = row_num * COLS;
    assign col      = text_byte - ROW_FIRST;

    always_comb
    begin
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        ended_next  = ended_reg;
        job_push    = 1'b0;
        job.idx     = '0;
        job.base    = ent.base;
        job.n       = ent.n;
        job.x       = pen_x_reg;
        job.y       = pen_y_reg;
        if (accept)
        begin
            if (start_string)
            begin
                pen_x_next  = start_x;
                pen_y_next  = start_y;
                second_next = 1'b0;
                ended_next  = 1'b0;
            end
            job.x = pen_x_next;
            job.y = pen_y_next;
            if (!ended_next && ent.n != 8'd0)
            begin
                if (family_reg == FAM_GB2312)
                begin
                    if (!second_next)
                    begin
                        if (text_byte == 8'd0)
                        begin
                            ended_next = 1'b1;
                        end
                        else
                        begin
                            lead_next   = text_byte;
                            second_next = 1'b1;
                        end
                    end
                    else
                    begin
                        job_push = (text_byte >= ROW_FIRST) && (row_a || row_b);
                        job.idx  = idx_t'(row_base) + idx_t'(col)
                                 + (row_b ? B_OFFSET : idx_t'(0));
                        second_next = 1'b0;
                        pen_x_next  = pen_x_next + 16'(ent.adv);
                    end
                end
                else
                begin
                    second_next = 1'b0;
                    if (text_byte == 8'd0)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        job_push = (text_byte >= PRINT_LO) && (text_byte <= PRINT_HI);
                        job.idx  = idx_t'(text_byte - PRINT_LO);
                        pen_x_next = pen_x_next + 16'(ent.adv);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_reg <= 2'd0;
            size_reg   <= 3'd1;
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            lead_reg   <= '0;
            second_reg <= 1'b0;
            ended_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FAMILY: family_reg <= cfg_data[1:0];
                    CFG_SIZE:   size_reg   <= cfg_data;
                    default:    size_reg   <= size_reg;
                endcase
            end
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            lead_reg   <= lead_next;
            second_reg <= second_next;
            ended_reg  <= ended_next;
        end
    end

endmodule
`default_nettype wire

### rtl/frga_back.sv
`timescale 1ns / 1ps
`default_nettype none
module frga_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    input  wire frga_pkg::job_t job,
    output logic                job_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output frga_pkg::result_t   res
);
    import frga_pkg::*;

    logic        valid_reg;
    logic [20:0] prod_reg;
    logic [23:0] base_reg;
    logic [7:0]  n_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic        advance;

    // hold a filled multiply stage while the result queue is full
    assign advance  = !valid_reg || !res_full;
    assign job_pop  = job_valid && advance;
    assign res_push = valid_reg && !res_full;
    assign res.addr = base_reg + 24'(prod_reg);
    assign res.n    = n_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            prod_reg <= job.idx * job.n;
            base_reg <= job.base;
            n_reg    <= job.n;
            x_reg    <= job.x;
            y_reg    <= job.y;
        end
    end

endmodule
`default_nettype wire

### rtl/font_rom_glyph_address_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a byte that completes a glyph is written to the middle queue, then held in
//   the multiply stage, then written to the request queue, then shows on the ports.
// Throughput: one byte and one glyph request per cycle while neither queue is full, paced
//   by the multiply stage of the back end (glyph index times byte count, then add base).
// Reset (rst_n low, async): queues empty, pen and pair phase cleared, no string
//   active, family 0 and size 1 selected.
module font_rom_glyph_address_stream_top #(
    parameter int unsigned MID_DEPTH = frga_pkg::MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = frga_pkg::OUT_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input, queue style
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    input  wire logic        start_string,
    input  wire logic [15:0] start_x,
    input  wire logic [15:0] start_y,
    // glyph requests, queue style
    output logic             empty,
    input  wire logic        pop,
    output logic [23:0]      rom_address,
    output logic [7:0]       byte_count,
    output logic [15:0]      glyph_x,
    output logic [15:0]      glyph_y,
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [2:0]  cfg_data
);
    import frga_pkg::*;

    job_t    fe_job, be_job;
    logic    fe_push, mid_full, mid_empty, be_pop;
    result_t be_res, out_res;
    logic    res_push, res_full;

    // the user must write registers only between strings (not enforced here); take them at once
    assign cfg_ready = 1'b1;
    // stall the byte input only on a full middle queue
    assign full = mid_full;

    // front: tracks pen, pair phase and string end; classifies each byte
    frga_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .text_byte    (text_byte),
        .start_string (start_string),
        .start_x      (start_x),
        .start_y      (start_y),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .job_full     (mid_full),
        .job_push     (fe_push),
        .job          (fe_job)
    );

    // decouple front and back so each can stall on its own
    frga_fifo #(
        .W     ($bits(job_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_data (fe_job),
        .full    (mid_full),
        .rd_en   (be_pop),
        .rd_data (be_job),
        .empty   (mid_empty)
    );

    // back: multiply, then add base into the request queue
    frga_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!mid_empty),
        .job       (be_job),
        .job_pop   (be_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (be_res)
    );

    frga_fifo #(
        .W     ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (be_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign rom_address = out_res.addr;
    assign byte_count  = out_res.n;
    assign glyph_x     = out_res.x;
    assign glyph_y     = out_res.y;

endmodule
`default_nettype wire

### rtl/frga_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module frga_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [23:0] rom_address,
    input wire logic [7:0]  byte_count,
    input wire logic [15:0] glyph_x,
    input wire logic [15:0] glyph_y
);
    // every glyph size reads between 8 and 130 bytes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (byte_count >= 8'd8 && byte_count <= 8'd130))
        else $error("byte_count out of range");

    // every glyph sits in the lower 2 MiB of the ROM
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> rom_address[23:21] == 3'b000)
        else $error("rom_address beyond font area");

    // a waiting request holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rom_address) && $stable(byte_count)
                              && $stable(glyph_x) && $stable(glyph_y)))
        else $error("request changed while waiting");

    // nothing is waiting right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty)
        else $error("request queue not empty after reset");

endmodule

bind font_rom_glyph_address_stream_top frga_checker u_frga_checker (.*);
`default_nettype wire
